FILE: rtl/string_literal_span_finder_core_macros.svh
// assertion macros shared by the rtl
`ifndef STRING_LITERAL_SPAN_FINDER_CORE_MACROS_SVH
`define STRING_LITERAL_SPAN_FINDER_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define SLSF_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SLSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/slsf_pkg.sv
package slsf_pkg;

    localparam int COL_W = 13;
    localparam logic [COL_W-1:0] MAX_LINE = 13'd4096;

    localparam logic [15:0] CH_DQ  = 16'h0022;
    localparam logic [15:0] CH_SQ  = 16'h0027;
    localparam logic [15:0] CH_BS  = 16'h005C;
    localparam logic [15:0] CH_NL  = 16'h000A;
    localparam logic [15:0] CH_NUL = 16'h0000;
    localparam logic [15:0] CH_SP  = 16'h0020;
    localparam logic [7:0]  CH_SP8 = 8'h20;

    localparam logic KIND_SPAN    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_OUTER  = 5'b00010,
        PH_INSIDE = 5'b00100,
        PH_ESCAPE = 5'b01000,
        PH_AFTER  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic             kind;
        logic [COL_W-1:0] span_begin;
        logic [COL_W-1:0] span_end;
        logic             starts_with_quote;
        logic             ends_open;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } scan_out_t;

    function automatic result_t make_span(logic [COL_W-1:0] b, logic [COL_W-1:0] e,
                                          logic last);
        result_t r;
        r.kind              = KIND_SPAN;
        r.span_begin        = b;
        r.span_end          = e;
        r.starts_with_quote = 1'b0;
        r.ends_open         = 1'b0;
        r.last              = last;
        return r;
    endfunction

    function automatic result_t make_summary(logic sq, logic eo);
        result_t r;
        r.kind              = KIND_SUMMARY;
        r.span_begin        = '0;
        r.span_end          = '0;
        r.starts_with_quote = sq;
        r.ends_open         = eo;
        r.last              = 1'b1;
        return r;
    endfunction

endpackage

FILE: rtl/slsf_scan.sv
module slsf_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [15:0]        ch,
    output slsf_pkg::scan_out_t res
);

    slsf_pkg::phase_t                 phase_reg, phase_next;
    logic                             qd_reg, qd_next;
    logic [slsf_pkg::COL_W-1:0]       column_reg, column_next;
    logic [slsf_pkg::COL_W-1:0]       lit_reg, lit_next;
    logic [slsf_pkg::COL_W-1:0]       close_reg, close_next;
    logic                             begin_reg, begin_next;
    logic                             end_reg, end_next;

    logic                             eol;
    logic                             is_quote;
    logic                             is_term;
    logic                             do_open;
    logic                             end_f;
    logic                             have_span;
    logic [slsf_pkg::COL_W-1:0]       span_e;
    logic [slsf_pkg::COL_W-1:0]       col_inc;

    assign eol      = (ch == slsf_pkg::CH_NUL) || (ch == slsf_pkg::CH_NL);
    assign is_quote = (ch == slsf_pkg::CH_DQ) || (ch == slsf_pkg::CH_SQ);
    assign is_term  = qd_reg ? (ch == slsf_pkg::CH_DQ) : (ch == slsf_pkg::CH_SQ);
    assign col_inc  = (column_reg >= slsf_pkg::MAX_LINE) ? slsf_pkg::MAX_LINE
                                                         : column_reg + 13'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        qd_next     = qd_reg;
        column_next = column_reg;
        lit_next    = lit_reg;
        close_next  = close_reg;
        begin_next  = begin_reg;
        end_next    = end_reg;
        res         = '0;
        do_open     = 1'b0;
        end_f       = end_reg;
        have_span   = 1'b0;
        span_e      = column_reg;

        if (eol)
        begin
            // line end: flush any open double-quoted literal, then the summary
            if (phase_reg == slsf_pkg::PH_AFTER)
            begin
                end_f     = 1'b1;
                have_span = qd_reg;
                span_e    = close_reg;
            end
            else if (phase_reg == slsf_pkg::PH_INSIDE || phase_reg == slsf_pkg::PH_ESCAPE)
            begin
                have_span = qd_reg;
            end
            if (have_span)
            begin
                res.cnt = 2'd2;
                res.r0  = slsf_pkg::make_span(lit_reg, span_e, 1'b0);
                res.r1  = slsf_pkg::make_summary(begin_reg, end_f);
            end
            else
            begin
                res.cnt = 2'd1;
                res.r0  = slsf_pkg::make_summary(begin_reg, end_f);
            end
            phase_next  = slsf_pkg::PH_LEAD;
            qd_next     = 1'b0;
            column_next = '0;
            lit_next    = '0;
            close_next  = '0;
            begin_next  = 1'b0;
            end_next    = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                slsf_pkg::PH_LEAD:
                begin
                    if (ch > slsf_pkg::CH_SP)
                    begin
                        begin_next = (ch == slsf_pkg::CH_DQ);
                        do_open    = 1'b1;
                    end
                end
                slsf_pkg::PH_INSIDE:
                begin
                    if (is_term)
                    begin
                        close_next = col_inc;
                        phase_next = slsf_pkg::PH_AFTER;
                    end
                    else if (ch == slsf_pkg::CH_BS)
                    begin
                        phase_next = slsf_pkg::PH_ESCAPE;
                    end
                end
                slsf_pkg::PH_ESCAPE:
                begin
                    phase_next = slsf_pkg::PH_INSIDE;
                end
                slsf_pkg::PH_AFTER:
                begin
                    // whitespace test uses the low byte only
                    if (ch[7:0] > slsf_pkg::CH_SP8)
                    begin
                        if (is_term)
                        begin
                            phase_next = slsf_pkg::PH_INSIDE;
                        end
                        else
                        begin
                            end_next = 1'b0;
                            do_open  = 1'b1;
                            if (qd_reg)
                            begin
                                res.cnt = 2'd1;
                                res.r0  = slsf_pkg::make_span(lit_reg, close_reg, 1'b1);
                            end
                        end
                    end
                end
                default:
                begin
                    do_open = 1'b1;
                end
            endcase

            if (do_open)
            begin
                if (is_quote)
                begin
                    qd_next    = (ch == slsf_pkg::CH_DQ);
                    lit_next   = column_reg;
                    phase_next = slsf_pkg::PH_INSIDE;
                end
                else
                begin
                    phase_next = slsf_pkg::PH_OUTER;
                end
            end
            column_next = col_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= slsf_pkg::PH_LEAD;
            qd_reg     <= 1'b0;
            column_reg <= '0;
            lit_reg    <= '0;
            close_reg  <= '0;
            begin_reg  <= 1'b0;
            end_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            qd_reg     <= qd_next;
            column_reg <= column_next;
            lit_reg    <= lit_next;
            close_reg  <= close_next;
            begin_reg  <= begin_next;
            end_reg    <= end_next;
        end
    end

endmodule

FILE: rtl/slsf_outq.sv
`include "string_literal_span_finder_core_macros.svh"

module slsf_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_cnt,
    input  slsf_pkg::result_t      push_r0,
    input  slsf_pkg::result_t      push_r1,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output slsf_pkg::result_t      out_data
);

    slsf_pkg::result_t                    mem_reg [slsf_pkg::Q_DEPTH];
    logic [slsf_pkg::Q_PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [slsf_pkg::Q_PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [slsf_pkg::Q_CNT_W-1:0]         count_reg, count_next;
    logic [slsf_pkg::Q_PTR_W-1:0]         wr_ptr_inc;
    logic                                 pop;

    // room for the two results a line end can cause
    assign room       = (count_reg <= 3'(slsf_pkg::Q_DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_r0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push_r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SLSF_ASSERT(a_count_bound, count_reg <= 3'(slsf_pkg::Q_DEPTH), "result queue overflow")
    `SLSF_ASSERT(a_push_room, (push_cnt == 2'd0) || room, "push without room")
    `SLSF_ASSERT_NEXT(a_pop_only, pop && (push_cnt == 2'd0),
        count_reg == $past(count_reg) - 3'd1, "pop count mismatch")
    `SLSF_ASSERT_NEXT(a_pair_push, (push_cnt == 2'd2) && !pop,
        count_reg == $past(count_reg) + 3'd2, "pair push count mismatch")

endmodule

FILE: rtl/string_literal_span_finder_core.sv
// string literal span finder
// input channel: in_valid/in_ready carry one character ch per item; 0 or 10
// ends the line. output channel: out_valid/out_ready carry one result per item,
// kind 0 = double-quoted literal span (span_begin/span_end columns), kind 1 =
// line summary (starts_with_quote, ends_open). last marks the final result
// caused by one input item.
// results pass in order through a registered result queue. throughput: one
// character per cycle while the queue has room; a line end that flushes an
// open literal causes two results, which drain one per cycle with out_ready high.
// in_ready follows a four-entry result queue that must have room for two
// results; when the receiver stalls the queue fills and in_ready drops, and
// no result is lost. single-quoted literals cause no results.
// reset: the scanner returns to the leading-blank state at column zero and the
// result queue empties; out_valid is low and in_ready high right after reset.
module string_literal_span_finder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [15:0]                   ch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [slsf_pkg::COL_W-1:0]    span_begin,
    output logic [slsf_pkg::COL_W-1:0]    span_end,
    output logic                          starts_with_quote,
    output logic                          ends_open,
    output logic                          last
);

    logic                  fire;
    logic                  room;
    logic [1:0]            push_cnt;
    slsf_pkg::scan_out_t   scan_res;
    slsf_pkg::result_t     head;

    assign in_ready = room;
    assign fire     = in_valid && room;
    assign push_cnt = fire ? scan_res.cnt : 2'd0;

    slsf_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch),
        .res   (scan_res)
    );

    slsf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_r0   (scan_res.r0),
        .push_r1   (scan_res.r1),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head)
    );

    assign kind              = head.kind;
    assign span_begin        = head.span_begin;
    assign span_end          = head.span_end;
    assign starts_with_quote = head.starts_with_quote;
    assign ends_open         = head.ends_open;
    assign last              = head.last;

endmodule

FILE: verif/string_literal_span_finder_core_tb.sv
module string_literal_span_finder_core_tb;
    import slsf_pkg::*;

    localparam int IDLE_PCT = 32;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_FROM = 2500;
    localparam int CALM_TO = 4000;
    localparam int HOLD_AT = 1500;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_FILL = 4094;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] ch = CH_NUL;
    logic out_valid;
    logic out_ready = 1'b0;
    logic kind;
    logic [COL_W-1:0] span_begin;
    logic [COL_W-1:0] span_end;
    logic starts_with_quote;
    logic ends_open;
    logic last;

    string_literal_span_finder_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .ch                (ch),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .kind              (kind),
        .span_begin        (span_begin),
        .span_end          (span_end),
        .starts_with_quote (starts_with_quote),
        .ends_open         (ends_open),
        .last              (last)
    );

    logic [15:0] char_q [$];
    result_t span_summary_q [$];
    int queued_items = 0;
    int errors = 0;
    int cyc = 0;
    int hold_left = 0;
    logic calm;

    // scanner state of the predictor
    phase_t line_phase = PH_LEAD;
    logic line_dbl = 1'b0;
    logic [COL_W-1:0] col = '0;
    logic [COL_W-1:0] lit_start = '0;
    logic [COL_W-1:0] close_lim = '0;
    logic line_bflag = 1'b0;
    logic line_eflag = 1'b0;

    // blank lines, continued literals, escapes, high-byte whitespace
    logic [15:0] opening_chars [29] = '{
        CH_NL,
        CH_SP, 16'h0001, CH_DQ, 16'h0041, CH_DQ, CH_NUL,
        CH_SQ, CH_BS, CH_SQ, CH_SQ, 16'h0120, CH_DQ, 16'hFFFF, CH_NL,
        16'h0120, CH_DQ, CH_DQ, 16'h0100, 16'h010A, CH_DQ, CH_DQ, 16'h0041,
        CH_DQ, CH_BS, CH_NUL,
        CH_SP, 16'h0009, CH_NL
    };

    assign calm = (cyc >= CALM_FROM && cyc < CALM_TO);

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) cyc <= cyc + 1;

    function automatic logic [COL_W-1:0] bump_col(input logic [COL_W-1:0] v);
        return (v >= MAX_LINE) ? MAX_LINE : v + 1'b1;
    endfunction

    function automatic result_t span_result(input logic [COL_W-1:0] b,
                                            input logic [COL_W-1:0] e);
        result_t r;
        r.kind = KIND_SPAN;
        r.span_begin = b;
        r.span_end = e;
        r.starts_with_quote = 1'b0;
        r.ends_open = 1'b0;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic enter_text(input logic [15:0] c);
        if (c == CH_DQ || c == CH_SQ)
        begin
            line_dbl = (c == CH_DQ);
            lit_start = col;
            line_phase = PH_INSIDE;
        end
        else
            line_phase = PH_OUTER;
    endtask

    task automatic scan_char(input logic [15:0] c);
        result_t found [2];
        int n;
        logic [15:0] term;
        n = 0;
        term = line_dbl ? CH_DQ : CH_SQ;
        if (c == CH_NUL || c == CH_NL)
        begin
            if (line_phase == PH_AFTER)
            begin
                line_eflag = 1'b1;
                if (line_dbl)
                begin
                    found[n] = span_result(lit_start, close_lim);
                    n++;
                end
            end
            else if (line_phase == PH_INSIDE || line_phase == PH_ESCAPE)
            begin
                if (line_dbl)
                begin
                    found[n] = span_result(lit_start, col);
                    n++;
                end
            end
            found[n] = span_result('0, '0);
            found[n].kind = KIND_SUMMARY;
            found[n].starts_with_quote = line_bflag;
            found[n].ends_open = line_eflag;
            n++;
            line_phase = PH_LEAD;
            line_dbl = 1'b0;
            col = '0;
            lit_start = '0;
            close_lim = '0;
            line_bflag = 1'b0;
            line_eflag = 1'b0;
        end
        else
        begin
            case (line_phase)
                PH_LEAD:
                    if (c > CH_SP)
                    begin
                        line_bflag = (c == CH_DQ);
                        enter_text(c);
                    end
                PH_INSIDE:
                    if (c == term)
                    begin
                        close_lim = bump_col(col);
                        line_phase = PH_AFTER;
                    end
                    else if (c == CH_BS)
                        line_phase = PH_ESCAPE;
                PH_ESCAPE:
                    line_phase = PH_INSIDE;
                PH_AFTER:
                    if (c[7:0] > CH_SP8)
                    begin
                        if (c == term)
                            line_phase = PH_INSIDE;
                        else
                        begin
                            line_eflag = 1'b0;
                            if (line_dbl)
                            begin
                                found[n] = span_result(lit_start, close_lim);
                                n++;
                            end
                            enter_text(c);
                        end
                    end
                default:
                    enter_text(c);
            endcase
            col = bump_col(col);
        end
        for (int i = 0; i < n; i++)
        begin
            found[i].last = (i == n - 1);
            span_summary_q.push_back(found[i]);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic queue_char(input logic [15:0] c);
        char_q.push_back(c);
        queued_items++;
    endtask

    function automatic logic [15:0] text_char();
        logic [15:0] c;
        case ($urandom_range(9))
            0: c = CH_DQ;
            1: c = CH_SQ;
            2: c = CH_BS;
            3: c = 16'($urandom_range(32, 1));
            4: c = {8'($urandom_range(255, 1)), 8'($urandom_range(32))};
            5, 6: c = 16'($urandom_range(16'h7E, 16'h21));
            default: c = 16'($urandom);
        endcase
        if (c == CH_NUL || c == CH_NL)
            c = c | 16'h0100;
        return c;
    endfunction

    function automatic logic [15:0] gap_char();
        logic [15:0] c;
        c = {($urandom_range(1) != 0) ? 8'($urandom) : 8'h00, 8'($urandom_range(32))};
        if (c == CH_NUL || c == CH_NL)
            c = c | 16'h0100;
        return c;
    endfunction

    task automatic build_line();
        logic [15:0] q;
        logic [15:0] c;
        bit cut;
        bit more;
        int segs;
        int len;
        cut = 1'b0;
        repeat ($urandom_range(3)) queue_char(16'($urandom_range(32, 1)));
        segs = $urandom_range(5);
        for (int s = 0; s < segs && !cut; s++)
        begin
            case ($urandom_range(9))
                0, 1: queue_char(text_char());
                2: queue_char(16'($urandom_range(32, 1)));
                default:
                begin
                    q = ($urandom_range(9) < 7) ? CH_DQ : CH_SQ;
                    queue_char(q);
                    do
                    begin
                        more = 1'b0;
                        len = $urandom_range(5);
                        for (int k = 0; k < len && !cut; k++)
                        begin
                            c = text_char();
                            if (c == CH_BS)
                            begin
                                queue_char(c);
                                if ($urandom_range(19) == 0)
                                    cut = 1'b1;
                                else
                                    queue_char(text_char());
                            end
                            else if (c != q)
                                queue_char(c);
                        end
                        if (!cut && $urandom_range(9) != 0)
                        begin
                            queue_char(q);
                            repeat ($urandom_range(2)) queue_char(gap_char());
                            if ($urandom_range(2) == 0)
                            begin
                                queue_char(q);
                                more = 1'b1;
                            end
                        end
                        else
                            cut = 1'b1;
                    end
                    while (more && !cut);
                end
            endcase
        end
        queue_char(($urandom_range(1) != 0) ? CH_NL : CH_NUL);
    endtask

    // column saturation: quotes placed just below, at and past the column limit
    task automatic build_long_line();
        repeat (LONG_FILL) queue_char(16'h0061 + 16'($urandom_range(25)));
        queue_char(CH_DQ);
        queue_char(16'h0061);
        queue_char(CH_DQ);
        queue_char(CH_SP);
        queue_char(CH_DQ);
        queue_char(16'h0062);
        queue_char(CH_DQ);
        queue_char(16'h0063);
        queue_char(CH_DQ);
        queue_char(16'h0078);
        queue_char(CH_NL);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch <= CH_NUL;
        end
        else
        begin
            if (in_valid && in_ready)
                scan_char(ch);
            if (!in_valid || in_ready)
            begin
                if (char_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    ch <= char_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {kind, span_begin, span_end, starts_with_quote, ends_open, last};
                if (span_summary_q.size() == 0)
                    report_mismatch($sformatf("unexpected item kind %0d begin %0d end %0d",
                                              got.kind, got.span_begin, got.span_end));
                else
                begin
                    want = span_summary_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got %0d/%0d/%0d/%0d/%0d/%0d wanted %0d/%0d/%0d/%0d/%0d/%0d",
                            got.kind, got.span_begin, got.span_end,
                            got.starts_with_quote, got.ends_open, got.last,
                            want.kind, want.span_begin, want.span_end,
                            want.starts_with_quote, want.ends_open, want.last));
                end
            end
            if (cyc == HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("string_literal_span_finder_core verification failed");
        $finish;
    end

    initial
    begin
        bit long_done;
        int long_items;
        long_done = 1'b0;
        long_items = 0;
        foreach (opening_chars[i]) queue_char(opening_chars[i]);
        while (queued_items - long_items < $size(opening_chars) + RANDOM_ITEMS)
        begin
            if (!long_done && queued_items > 300)
            begin
                long_items = queued_items;
                build_long_line();
                long_items = queued_items - long_items;
                long_done = 1'b1;
            end
            build_line();
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (char_q.size() != 0 || in_valid)
            @(posedge clk);
        while (span_summary_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("string_literal_span_finder_core verification clean");
        else
            $display("string_literal_span_finder_core verification failed");
        $finish;
    end
endmodule
